FILE: design/lce_pkg.sv
`default_nettype none

package lce_pkg;

    localparam int SIZE_W = 48;
    localparam int AGE_W  = 63;
    localparam int REM_W  = 53;
    localparam int IDX_OUT_W = 5;

    // One stored entry, without its valid bit and load position
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [AGE_W-1:0]  age;
        logic              kept;
        logic              busy;
    } t_entry;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_CLEAR
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

`default_nettype wire

FILE: design/lce_cell.sv
`default_nettype none

module lce_cell #(
    parameter int IW = 5
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lce_pkg::t_cell_op    i_op,
    input  lce_pkg::t_entry      i_new,
    input  wire  [IW-1:0]        i_new_idx,
    input  lce_pkg::t_entry      i_left,
    input  wire  [IW-1:0]        i_left_idx,
    input  wire                  i_left_valid,
    input  wire                  i_left_gt,
    input  lce_pkg::t_entry      i_right,
    input  wire  [IW-1:0]        i_right_idx,
    input  wire                  i_right_valid,
    output lce_pkg::t_entry      o_entry,
    output logic [IW-1:0]        o_idx,
    output logic                 o_valid,
    output logic                 o_gt
);
    import lce_pkg::*;

    logic          r_valid, n_valid;
    t_entry        r_entry, n_entry;
    logic [IW-1:0] r_idx,   n_idx;

    // New entry goes at or before this cell: empty, or strictly newer than the new one
    assign o_gt    = !r_valid || (r_entry.age > i_new.age);
    assign o_entry = r_entry;
    assign o_idx   = r_idx;
    assign o_valid = r_valid;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        n_idx   = r_idx;
        unique case (i_op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (o_gt) begin
                    if (i_left_gt) begin
                        n_valid = i_left_valid;
                        n_entry = i_left;
                        n_idx   = i_left_idx;
                    end else begin
                        n_valid = 1'b1;
                        n_entry = i_new;
                        n_idx   = i_new_idx;
                    end
                end
            end
            CELL_POP: begin
                n_valid = i_right_valid;
                n_entry = i_right;
                n_idx   = i_right_idx;
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_idx   <= n_idx;
    end

endmodule

`default_nettype wire

FILE: design/lru_capacity_evictor.sv
`default_nettype none

// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+---------------------------------------
// config    | in        | i_cfg_we                 | i_cfg_wdata (capacity_limit)
// in        | in        | i_in_valid / o_in_stall  | i_kind, i_entry_size, i_last_used,
//           |           |                          | i_is_kept, i_is_busy, i_incoming_size
// out       | out       | o_out_valid / i_out_stall| o_is_summary, o_evicted_index, ...
//
// Loads can be accepted back to back.
// An evaluate transaction is accepted and then walks the chain, one chain pop per
// step up to MAX_ENTRIES pops plus the summary; the input is stalled for the whole walk.
// Reset (i_rst_n low, synchronous) empties the chain and clears the capacity.
// A stalled output holds the walk on emitting steps; skip steps still advance.

module lru_capacity_evictor #(
    parameter int MAX_ENTRIES = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [lce_pkg::SIZE_W-1:0]   i_cfg_wdata,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_kind,
    input  wire  [lce_pkg::SIZE_W-1:0]   i_entry_size,
    input  wire  [lce_pkg::AGE_W-1:0]    i_last_used,
    input  wire                          i_is_kept,
    input  wire                          i_is_busy,
    input  wire  [lce_pkg::SIZE_W-1:0]   i_incoming_size,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_is_summary,
    output logic [lce_pkg::IDX_OUT_W-1:0] o_evicted_index,
    output logic [lce_pkg::SIZE_W-1:0]   o_evicted_size,
    output logic [lce_pkg::REM_W-1:0]    o_remaining_total,
    output logic                         o_fits,
    output logic                         o_dropped_entries,
    output logic                         o_last
);
    import lce_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    // Running total: MAX_ENTRIES sizes of SIZE_W bits each
    localparam int TW = SIZE_W + $clog2(MAX_ENTRIES);
    // Total plus incoming size
    localparam int NW = TW + 1;
    localparam logic [63:0] REM_MAX = (64'd1 << REM_W) - 64'd1;

    // Control state
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [TW-1:0]     r_total, n_total;
    logic [NW-1:0]     r_need,  n_need;
    logic              r_overflow, n_overflow;
    logic [SIZE_W-1:0] r_cap;

    // Output register
    logic                 r_out_valid;
    logic                 r_out_summary;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [SIZE_W-1:0]    r_out_size;
    logic [REM_W-1:0]     r_out_rem;
    logic                 r_out_fits;
    logic                 r_out_drop;

    // Chain wiring
    t_entry        c_entry [MAX_ENTRIES];
    logic [IW-1:0] c_idx   [MAX_ENTRIES];
    logic          c_valid [MAX_ENTRIES];
    logic          c_gt    [MAX_ENTRIES];

    t_cell_op      cell_op;
    t_entry        new_entry;
    logic [IW-1:0] new_idx;

    logic          in_acc, do_load, do_eval;
    logic          slot_free, fits_now;
    logic          emit_evict, emit_summary;
    logic [TW-1:0] evict_total;
    logic [NW-1:0] evict_need;
    logic [63:0]   rem_wide;
    logic [REM_W-1:0] rem_sat;

    t_entry head;
    logic   head_valid;

    assign head       = c_entry[0];
    assign head_valid = c_valid[0];

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign do_load    = in_acc && !i_kind;
    assign do_eval    = in_acc && i_kind;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign fits_now   = (r_need <= NW'(r_cap));

    assign new_entry.size = i_entry_size;
    assign new_entry.age  = i_last_used;
    assign new_entry.kept = i_is_kept;
    assign new_entry.busy = i_is_busy;
    assign new_idx        = IW'(r_count);

    // Totals after evicting the head entry
    assign evict_total = r_total - TW'(head.size);
    assign evict_need  = r_need - NW'(head.size);

    // Row of cells: sorted oldest first, ties kept in load order
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_entry        left_e, right_e;
        logic [IW-1:0] left_i, right_i;
        logic          left_v, left_g, right_v;

        if (g == 0) begin : g_head
            assign left_e = '0;
            assign left_i = '0;
            assign left_v = 1'b0;
            assign left_g = 1'b0;
        end else begin : g_mid
            assign left_e = c_entry[g-1];
            assign left_i = c_idx[g-1];
            assign left_v = c_valid[g-1];
            assign left_g = c_gt[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign right_e = '0;
            assign right_i = '0;
            assign right_v = 1'b0;
        end else begin : g_body
            assign right_e = c_entry[g+1];
            assign right_i = c_idx[g+1];
            assign right_v = c_valid[g+1];
        end

        lce_cell #(
            .IW (IW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (cell_op),
            .i_new         (new_entry),
            .i_new_idx     (new_idx),
            .i_left        (left_e),
            .i_left_idx    (left_i),
            .i_left_valid  (left_v),
            .i_left_gt     (left_g),
            .i_right       (right_e),
            .i_right_idx   (right_i),
            .i_right_valid (right_v),
            .o_entry       (c_entry[g]),
            .o_idx         (c_idx[g]),
            .o_valid       (c_valid[g]),
            .o_gt          (c_gt[g])
        );
    end

    // Next state and chain command
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_total      = r_total;
        n_need       = r_need;
        n_overflow   = r_overflow;
        cell_op      = CELL_HOLD;
        emit_evict   = 1'b0;
        emit_summary = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (do_load) begin
                    if (r_count < CW'(MAX_ENTRIES)) begin
                        cell_op = CELL_INSERT;
                        n_count = r_count + CW'(1);
                        n_total = r_total + TW'(i_entry_size);
                    end else begin
                        // Table full: drop the entry and remember it
                        n_overflow = 1'b1;
                    end
                end else if (do_eval) begin
                    n_need  = NW'(r_total) + NW'(i_incoming_size);
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                priority if (fits_now || !head_valid) begin
                    // Store fits or nothing left: close the run and empty the table
                    if (slot_free) begin
                        emit_summary = 1'b1;
                        cell_op      = CELL_CLEAR;
                        n_count      = '0;
                        n_total      = '0;
                        n_overflow   = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else if (head.kept || head.busy) begin
                    // Skip protected entries without a result
                    cell_op = CELL_POP;
                end else begin
                    if (slot_free) begin
                        emit_evict = 1'b1;
                        cell_op    = CELL_POP;
                        n_total    = evict_total;
                        n_need     = evict_need;
                    end
                end
            end
        endcase
    end

    // Saturate the reported total to the output width
    assign rem_wide = emit_evict ? 64'(evict_total) : 64'(r_total);
    assign rem_sat  = (rem_wide > REM_MAX) ? REM_MAX[REM_W-1:0] : rem_wide[REM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_overflow  <= 1'b0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_total    <= n_total;
            r_overflow <= n_overflow;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (emit_evict || emit_summary) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_need <= n_need;
        if (emit_evict) begin
            r_out_summary <= 1'b0;
            r_out_idx     <= IDX_OUT_W'(c_idx[0]);
            r_out_size    <= head.size;
            r_out_rem     <= rem_sat;
            r_out_fits    <= (evict_need <= NW'(r_cap));
            r_out_drop    <= 1'b0;
        end else if (emit_summary) begin
            r_out_summary <= 1'b1;
            r_out_idx     <= '0;
            r_out_size    <= '0;
            r_out_rem     <= rem_sat;
            r_out_fits    <= fits_now;
            r_out_drop    <= r_overflow;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_is_summary      = r_out_summary;
    assign o_evicted_index   = r_out_idx;
    assign o_evicted_size    = r_out_size;
    assign o_remaining_total = r_out_rem;
    assign o_fits            = r_out_fits;
    assign o_dropped_entries = r_out_drop;
    assign o_last            = r_out_summary;

    // A summary leaves the table empty and the block ready for loads
    a_summary_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_summary |=> (r_count == '0 && !c_valid[0] && r_state == ST_IDLE))
        else $error("table not empty after summary");

    // Before its summary step, the walk never changes the number of loaded entries
    a_walk_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && !emit_summary) |=> $stable(r_count))
        else $error("entry count moved during walk");

    // A load into a table with room lands in the chain
    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_load && r_count < CW'(MAX_ENTRIES)) |=>
            (r_count == $past(r_count) + CW'(1) && c_valid[0]))
        else $error("accepted load not stored");

endmodule

`default_nettype wire

FILE: bench/lce_tb_pkg.sv
`timescale 1ns / 1ps

package lce_tb_pkg;

    // Transaction kind on the input channel
    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } t_kind;

    // One result transaction as it leaves the evictor
    typedef struct packed {
        logic                            is_summary;
        logic [lce_pkg::IDX_OUT_W-1:0]   index;
        logic [lce_pkg::SIZE_W-1:0]      size;
        logic [lce_pkg::REM_W-1:0]       remaining;
        logic                            fits;
        logic                            dropped;
        logic                            last;
    } t_report;

endpackage

FILE: bench/lce_checker.sv
`timescale 1ns / 1ps

module lce_checker #(
    parameter int DEPTH = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [lce_pkg::SIZE_W-1:0]      i_cfg_wdata,
    input  wire                             i_in_valid,
    input  wire                             i_in_stall,
    input  wire                             i_kind,
    input  wire  [lce_pkg::SIZE_W-1:0]      i_entry_size,
    input  wire  [lce_pkg::AGE_W-1:0]       i_last_used,
    input  wire                             i_is_kept,
    input  wire                             i_is_busy,
    input  wire  [lce_pkg::SIZE_W-1:0]      i_incoming_size,
    input  wire                             i_out_valid,
    input  wire                             i_out_stall,
    input  wire                             i_is_summary,
    input  wire  [lce_pkg::IDX_OUT_W-1:0]   i_evicted_index,
    input  wire  [lce_pkg::SIZE_W-1:0]      i_evicted_size,
    input  wire  [lce_pkg::REM_W-1:0]       i_remaining_total,
    input  wire                             i_fits,
    input  wire                             i_dropped_entries,
    input  wire                             i_last,
    output int                              o_fail_count,
    output int                              o_pending
);
    import lce_tb_pkg::*;

    localparam int SIZE_W = lce_pkg::SIZE_W;
    localparam int AGE_W  = lce_pkg::AGE_W;
    localparam int REM_W  = lce_pkg::REM_W;
    localparam int IDX_W  = lce_pkg::IDX_OUT_W;

    logic [SIZE_W-1:0] slot_size [DEPTH];
    logic [AGE_W-1:0]  slot_age  [DEPTH];
    logic              slot_kept [DEPTH];
    logic              slot_busy [DEPTH];
    int                slot_fill;
    logic [63:0]       stored_bytes;
    logic              loads_dropped;
    logic [SIZE_W-1:0] capacity;
    t_report           eviction_reports_q [$];

    function automatic t_report make_report(input logic is_sum, input int slot,
                                            input logic [SIZE_W-1:0] freed,
                                            input logic [63:0] total,
                                            input logic fit, input logic drop);
        t_report rep;
        rep.is_summary = is_sum;
        rep.index      = IDX_W'(slot);
        rep.size       = freed;
        rep.remaining  = REM_W'(total);
        rep.fits       = fit;
        rep.dropped    = drop;
        rep.last       = is_sum;
        return rep;
    endfunction

    // Walk the table oldest first, earliest load winning a tie, and evict
    // until the incoming bytes fit; close with the summary and clear.
    task automatic predict_evictions(input logic [SIZE_W-1:0] incoming);
        logic [63:0] total;
        logic        visited [DEPTH];
        int          pick;
        total = stored_bytes;
        for (int s = 0; s < DEPTH; s++) visited[s] = 1'b0;
        if (total + 64'(incoming) > 64'(capacity)) begin
            for (int step = 0; step < slot_fill; step++) begin
                pick = -1;
                for (int s = 0; s < slot_fill; s++) begin
                    if (!visited[s] && (pick < 0 || slot_age[s] < slot_age[pick]))
                        pick = s;
                end
                visited[pick] = 1'b1;
                if (total + 64'(incoming) <= 64'(capacity))
                    break;
                if (slot_kept[pick] || slot_busy[pick])
                    continue;
                total = total - 64'(slot_size[pick]);
                eviction_reports_q = {eviction_reports_q,
                    make_report(1'b0, pick, slot_size[pick], total,
                                total + 64'(incoming) <= 64'(capacity), 1'b0)};
            end
        end
        eviction_reports_q = {eviction_reports_q,
            make_report(1'b1, 0, '0, total,
                        total + 64'(incoming) <= 64'(capacity), loads_dropped)};
        slot_fill     = 0;
        stored_bytes  = '0;
        loads_dropped = 1'b0;
    endtask

    function automatic int field_diff(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (want === got)
            return 0;
        $error("%s: expected %0h, actual %0h", name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_report want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            slot_fill     = 0;
            stored_bytes  = '0;
            loads_dropped = 1'b0;
            capacity      = '0;
            eviction_reports_q.delete();
        end else begin
            if (i_cfg_we)
                capacity = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_LOAD) begin
                    if (slot_fill < DEPTH) begin
                        slot_size[slot_fill] = i_entry_size;
                        slot_age[slot_fill]  = i_last_used;
                        slot_kept[slot_fill] = i_is_kept;
                        slot_busy[slot_fill] = i_is_busy;
                        stored_bytes = stored_bytes + 64'(i_entry_size);
                        slot_fill++;
                    end else begin
                        loads_dropped = 1'b1;
                    end
                end else begin
                    predict_evictions(i_incoming_size);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (eviction_reports_q.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    errs = 1;
                end else begin
                    want = eviction_reports_q.pop_front();
                    errs += field_diff("is_summary", 64'(want.is_summary), 64'(i_is_summary));
                    errs += field_diff("evicted_index", 64'(want.index), 64'(i_evicted_index));
                    errs += field_diff("evicted_size", 64'(want.size), 64'(i_evicted_size));
                    errs += field_diff("remaining_total", 64'(want.remaining),
                                       64'(i_remaining_total));
                    errs += field_diff("fits", 64'(want.fits), 64'(i_fits));
                    errs += field_diff("dropped_entries", 64'(want.dropped),
                                       64'(i_dropped_entries));
                    errs += field_diff("last", 64'(want.last), 64'(i_last));
                end
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_pending    <= eviction_reports_q.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lce_tb_pkg::*;

    localparam int SIZE_W = lce_pkg::SIZE_W;
    localparam int AGE_W  = lce_pkg::AGE_W;

    localparam int SLOTS         = 32;
    // A walk pops at most every slot and then emits the summary; leave margin.
    localparam int SETTLE_CYCLES = 40;
    // Cycles with no transaction on either channel before the run is called hung.
    localparam int IDLE_LIMIT    = 5000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int PHASE_ITEMS   = 75;

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
    localparam logic [AGE_W-1:0]  AGE_MAX  = '1;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Configuration port
    logic              cfg_we    = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    // Input channel
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic              kind          = KIND_LOAD;
    logic [SIZE_W-1:0] entry_size    = '0;
    logic [AGE_W-1:0]  last_used     = '0;
    logic              is_kept       = 1'b0;
    logic              is_busy       = 1'b0;
    logic [SIZE_W-1:0] incoming_size = '0;

    // Output channel
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          is_summary;
    logic [lce_pkg::IDX_OUT_W-1:0] evicted_index;
    logic [SIZE_W-1:0]             evicted_size;
    logic [lce_pkg::REM_W-1:0]     remaining_total;
    logic                          fits;
    logic                          dropped_entries;
    logic                          last_flag;

    int fail_count;
    int pending;

    // Stimulus bookkeeping
    logic [SIZE_W-1:0] capacity_now = '0;
    logic [SIZE_W-1:0] incoming;
    bit                calm = 1'b0;   // no gaps on either side while set
    bit                narrow_ages;
    bit                pinned;
    int                items_sent;
    int                phase_start;
    int                phase;
    int                batch_len;
    int                cap_bits;
    int                size_bits;
    int                r;
    int                idle_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lru_capacity_evictor #(
        .MAX_ENTRIES(SLOTS)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_kind           (kind),
        .i_entry_size     (entry_size),
        .i_last_used      (last_used),
        .i_is_kept        (is_kept),
        .i_is_busy        (is_busy),
        .i_incoming_size  (incoming_size),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_is_summary     (is_summary),
        .o_evicted_index  (evicted_index),
        .o_evicted_size   (evicted_size),
        .o_remaining_total(remaining_total),
        .o_fits           (fits),
        .o_dropped_entries(dropped_entries),
        .o_last           (last_flag)
    );

    lce_checker #(
        .DEPTH(SLOTS)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_kind           (kind),
        .i_entry_size     (entry_size),
        .i_last_used      (last_used),
        .i_is_kept        (is_kept),
        .i_is_busy        (is_busy),
        .i_incoming_size  (incoming_size),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_is_summary     (is_summary),
        .i_evicted_index  (evicted_index),
        .i_evicted_size   (evicted_size),
        .i_remaining_total(remaining_total),
        .i_fits           (fits),
        .i_dropped_entries(dropped_entries),
        .i_last           (last_flag),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Random value of w bits; the upper bits stay zero.
    function automatic logic [63:0] rand_bits(input int w);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (w <= 0)
            return '0;
        return v >> (64 - w);
    endfunction

    // Idle length: mostly none or short, now and then a long stretch.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // All drive tasks start and end just after a falling edge.
    task automatic send_item(input t_kind k, input logic [SIZE_W-1:0] sz,
                             input logic [AGE_W-1:0] age, input logic kp,
                             input logic bz, input logic [SIZE_W-1:0] inc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        entry_size    <= sz;
        last_used     <= age;
        is_kept       <= kp;
        is_busy       <= bz;
        incoming_size <= inc;
        // Hold the payload until the evictor takes it.
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // Loads ignore incoming_size and evaluates ignore the entry fields;
    // randomize the unused ones anyway.
    task automatic load_entry(input logic [SIZE_W-1:0] sz, input logic [AGE_W-1:0] age,
                              input logic kp, input logic bz);
        send_item(KIND_LOAD, sz, age, kp, bz, SIZE_W'(rand_bits(SIZE_W)));
    endtask

    task automatic evaluate(input logic [SIZE_W-1:0] inc);
        send_item(KIND_EVAL, SIZE_W'(rand_bits(SIZE_W)), AGE_W'(rand_bits(AGE_W)),
                  1'($urandom), 1'($urandom), inc);
    endtask

    // Drain: drop valid, wait out every expected result, then give the walk
    // time to retire before anything touches the configuration.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [SIZE_W-1:0] value);
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        capacity_now  = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Output side back-pressure: stall bursts between runs of free cycles.
    initial begin : stall_gen
        int hold;
        forever begin
            @(negedge clk);
            hold = pick_gap();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
    end

    // Watchdog: restart the count on any transaction, give up on a hang.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("lru_capacity_evictor verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero capacity: an empty table fits nothing but zero bytes.
        write_capacity('0);
        evaluate('0);
        evaluate(SIZE_MAX);

        // Kept and busy entries at the oldest age must be skipped; two entries
        // tie on age and go in load order; everything evictable goes, and the
        // store still does not fit.
        load_entry('0, AGE_MAX, 1'b0, 1'b0);
        load_entry(SIZE_MAX, '0, 1'b1, 1'b0);
        load_entry(SIZE_MAX, '0, 1'b0, 1'b1);
        load_entry(48'd5, 63'd3, 1'b0, 1'b0);
        load_entry(48'd7, 63'd3, 1'b0, 1'b0);
        load_entry(48'd1, 63'd2, 1'b1, 1'b1);
        evaluate('0);
        settle();

        // Full capacity: an exact fit needs no eviction; a wide overflow
        // evicts the oldest until the incoming bytes fit.
        write_capacity(SIZE_MAX);
        load_entry(SIZE_MAX - 48'd1, 63'd10, 1'b0, 1'b0);
        evaluate(48'd1);
        load_entry(SIZE_MAX, 63'd5, 1'b0, 1'b0);
        load_entry(SIZE_MAX, 63'd5, 1'b0, 1'b0);
        load_entry(48'd3, 63'd4, 1'b0, 1'b0);
        evaluate(SIZE_MAX);
        settle();

        // Mid capacity: one eviction is enough, the kept twin stays.
        write_capacity(48'd1000);
        load_entry(48'd600, 63'd1, 1'b0, 1'b0);
        load_entry(48'd600, 63'd1, 1'b1, 1'b0);
        evaluate('0);

        // Random batches: a run of loads closed by an evaluate. Some batches
        // overrun the table so loads are dropped, a few are a bare evaluate.
        items_sent  = 0;
        phase       = 0;
        phase_start = -PHASE_ITEMS;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent - phase_start >= PHASE_ITEMS) begin
                settle();
                case (phase % 5)
                    0:       write_capacity(SIZE_MAX);
                    1:       write_capacity(SIZE_W'(rand_bits($urandom_range(10, 24))));
                    2:       write_capacity('0);
                    3:       write_capacity(SIZE_W'(rand_bits($urandom_range(24, 47))));
                    default: write_capacity(SIZE_W'(rand_bits($urandom_range(4, 12))));
                endcase
                phase++;
                phase_start = items_sent;
            end

            r = $urandom_range(0, 99);
            if (r < 12)
                batch_len = $urandom_range(SLOTS, SLOTS + 4);
            else if (r < 18)
                batch_len = 0;
            else
                batch_len = $urandom_range(1, SLOTS - 1);

            // Scale entry sizes to the capacity so that batches land on both
            // sides of the limit.
            cap_bits = 0;
            while (cap_bits < SIZE_W && (capacity_now >> cap_bits) != 0)
                cap_bits++;
            if ($urandom_range(0, 3) == 0)
                size_bits = $urandom_range(1, SIZE_W);
            else if (cap_bits > 6)
                size_bits = cap_bits - int'($urandom_range(2, 5));
            else
                size_bits = 1;

            narrow_ages = 1'($urandom_range(0, 1));   // narrow ages force ties
            pinned      = ($urandom_range(0, 9) == 0);  // nothing evictable
            calm        = ($urandom_range(0, 5) == 0);

            for (int n = 0; n < batch_len; n++) begin
                load_entry(SIZE_W'(rand_bits(size_bits)),
                           narrow_ages ? AGE_W'($urandom_range(0, 7))
                                       : AGE_W'(rand_bits($urandom_range(1, AGE_W))),
                           pinned || ($urandom_range(0, 3) == 0),
                           $urandom_range(0, 3) == 0);
            end

            r = $urandom_range(0, 99);
            if (r < 40)
                incoming = '0;
            else if (r < 75)
                incoming = SIZE_W'(rand_bits(cap_bits));
            else
                incoming = SIZE_W'(rand_bits($urandom_range(1, SIZE_W)));
            evaluate(incoming);
        end

        calm = 1'b0;
        settle();
        if (fail_count == 0 && pending == 0)
            $display("lru_capacity_evictor verification clean");
        else
            $display("lru_capacity_evictor verification failed");
        $finish;
    end

endmodule
